>>> rtl/core/pac_pkg.sv
// Shared widths, command and status types for the polygon area and centroid block.
package pac_pkg;

  localparam int COORD_W = 16;
  localparam int AREA_W = 40;
  localparam int TAS_W = 41;
  localparam int MOM_W = 58;
  localparam int PROD_W = 2 * COORD_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SUM_W = COORD_W + 1;
  localparam int MPROD_W = SUM_W + CROSS_W;
  localparam int DVS_W = TAS_W + 1;
  localparam int QUO_W = COORD_W + 1;
  localparam int DIV_STEPS = MOM_W;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  localparam logic [COORD_W-1:0] SAT_POS = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] SAT_NEG = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic load_in;
    logic set_first;
    logic edge_fwd;
    logic advance;
    logic edge_close;
    logic mul1;
    logic sub;
    logic mul2;
    logic acc;
    logic fin;
    logic over;
    logic div_step;
    logic pack;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_zero;
    logic cnt_lt_max;
    logic cnt_le_max;
    logic tas_pos;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/pac_ctrl.sv
// Sequencer for vertex intake, edge accumulation, division and result hand-off.
module pac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pac_pkg::status_t sts,
  output pac_pkg::cmd_t    cmd
);
  import pac_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_SUB  = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_TAIL = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_PACK = 4'd9;

  logic [3:0] state, state_next;
  logic closing, closing_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      closing <= 1'b0;
    end else begin
      state <= state_next;
      closing <= closing_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    closing_next = closing;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.advance = 1'b1;
        closing_next = 1'b0;
        if (sts.cnt_zero) begin
          cmd.set_first = 1'b1;
          state_next = S_TAIL;
        end else if (sts.cnt_lt_max) begin
          cmd.edge_fwd = 1'b1;
          state_next = S_MUL1;
        end else begin
          state_next = S_TAIL;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_SUB;
      end
      S_SUB: begin
        cmd.sub = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        state_next = closing ? S_FIN : S_TAIL;
      end
      S_TAIL: begin
        if (!sts.last) begin
          state_next = S_IDLE;
        end else if (sts.cnt_le_max) begin
          cmd.edge_close = 1'b1;
          closing_next = 1'b1;
          state_next = S_MUL1;
        end else begin
          cmd.over = 1'b1;
          state_next = S_PACK;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = sts.tas_pos ? S_DIV : S_PACK;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_PACK;
        end
      end
      S_PACK: begin
        if (sts.out_free) begin
          cmd.pack = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/pac_datapath.sv
// Vertex registers, shoelace multiply-accumulate, restoring divider and result word.
module pac_datapath #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pac_pkg::cmd_t                       cmd,
  output pac_pkg::status_t                    sts,
  input  logic signed [pac_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [pac_pkg::COORD_W-1:0]  vertex_y,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pac_pkg::AREA_W-1:0]   area,
  output logic signed [pac_pkg::COORD_W-1:0]  centroid_x,
  output logic signed [pac_pkg::COORD_W-1:0]  centroid_y,
  output logic                                area_valid
);
  import pac_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);

  function automatic logic [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    for (int i = 0; i < COORD_W; i++) begin
      r[i] = (i < COORD_BITS) ? v[i] : v[COORD_BITS-1];
    end
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_q(input logic [QUO_W-1:0] q, input logic o,
                                               input logic n);
    logic [QUO_W-1:0] nq;
    nq = -q;
    if (!n) begin
      return (o || q > QUO_W'(SAT_POS)) ? SAT_POS : q[COORD_W-1:0];
    end
    return (o || q > QUO_W'(SAT_POS) + QUO_W'(1)) ? SAT_NEG : nq[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] cur [2];
  logic signed [COORD_W-1:0] first [2];
  logic signed [COORD_W-1:0] prev [2];
  logic                      last_q;
  logic [CNT_W-1:0]          count;

  logic signed [COORD_W-1:0] op_a [2];
  logic signed [COORD_W-1:0] op_b [2];
  logic signed [PROD_W-1:0]  p1, p2;
  logic signed [SUM_W-1:0]   psum [2];
  logic signed [CROSS_W-1:0] cross_q;
  logic signed [MPROD_W-1:0] mprod [2];
  logic signed [TAS_W-1:0]   tas;
  logic signed [MOM_W-1:0]   mom [2];

  logic signed [TAS_W-1:0]   tas_rnd;
  logic signed [AREA_W-1:0]  area_w;
  logic                      valid_w;
  logic [DVS_W-1:0]          dvs;
  logic [MOM_W-1:0]          num [2];
  logic [DVS_W-1:0]          rem [2];
  logic [QUO_W-1:0]          quo [2];
  logic                      ovf [2];
  logic                      neg [2];
  logic [DCNT_W-1:0]         dcnt;

  logic [DVS_W:0]            shifted [2];
  logic                      ge [2];
  logic [DVS_W:0]            rem_sub [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      shifted[l] = {rem[l], num[l][MOM_W-1]};
      ge[l] = shifted[l] >= {1'b0, dvs};
      rem_sub[l] = shifted[l] - {1'b0, dvs};
    end
  end

  assign tas_rnd = tas + TAS_W'(tas[TAS_W-1]);

  assign sts.last = last_q;
  assign sts.cnt_zero = (count == '0);
  assign sts.cnt_lt_max = (count < CNT_MAX);
  assign sts.cnt_le_max = (count <= CNT_MAX);
  assign sts.tas_pos = !tas[TAS_W-1] && (tas != '0);
  assign sts.div_done = (dcnt == DCNT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid || out_ready;

  // vertex bookkeeping and accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.pack) begin
      count <= '0;
      tas <= '0;
      for (int l = 0; l < 2; l++) begin
        first[l] <= '0;
        prev[l] <= '0;
        mom[l] <= '0;
      end
    end else begin
      if (cmd.set_first) begin
        first[0] <= cur[0];
        first[1] <= cur[1];
      end
      if (cmd.advance) begin
        if (count <= CNT_MAX) begin
          count <= count + CNT_W'(1);
        end
        prev[0] <= cur[0];
        prev[1] <= cur[1];
      end
      if (cmd.mul2) begin
        tas <= tas + TAS_W'(cross_q);
      end
      if (cmd.acc) begin
        for (int l = 0; l < 2; l++) begin
          mom[l] <= mom[l] + MOM_W'(mprod[l]);
        end
      end
    end
  end

  // input word and multiply pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur[0] <= sext(vertex_x);
      cur[1] <= sext(vertex_y);
      last_q <= last_vertex;
    end
    if (cmd.edge_fwd) begin
      for (int l = 0; l < 2; l++) begin
        op_a[l] <= prev[l];
        op_b[l] <= cur[l];
      end
    end else if (cmd.edge_close) begin
      for (int l = 0; l < 2; l++) begin
        op_a[l] <= cur[l];
        op_b[l] <= first[l];
      end
    end
    if (cmd.mul1) begin
      p1 <= op_a[0] * op_b[1];
      p2 <= op_b[0] * op_a[1];
      for (int l = 0; l < 2; l++) begin
        psum[l] <= SUM_W'(op_a[l]) + SUM_W'(op_b[l]);
      end
    end
    if (cmd.sub) begin
      cross_q <= CROSS_W'(p1) - CROSS_W'(p2);
    end
    if (cmd.mul2) begin
      for (int l = 0; l < 2; l++) begin
        mprod[l] <= psum[l] * cross_q;
      end
    end
  end

  // divider lanes
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      area_w <= tas_rnd[TAS_W-1:1];
      valid_w <= sts.tas_pos;
      dvs <= DVS_W'({tas[TAS_W-2:0], 1'b0}) + DVS_W'(tas[TAS_W-2:0]);
      dcnt <= '0;
      for (int l = 0; l < 2; l++) begin
        neg[l] <= mom[l][MOM_W-1];
        num[l] <= mom[l][MOM_W-1] ? $unsigned(-mom[l]) : $unsigned(mom[l]);
        rem[l] <= '0;
        quo[l] <= '0;
        ovf[l] <= 1'b0;
      end
    end else if (cmd.over) begin
      area_w <= '0;
      valid_w <= 1'b0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + DCNT_W'(1);
      for (int l = 0; l < 2; l++) begin
        num[l] <= {num[l][MOM_W-2:0], 1'b0};
        rem[l] <= ge[l] ? rem_sub[l][DVS_W-1:0] : shifted[l][DVS_W-1:0];
        quo[l] <= {quo[l][QUO_W-2:0], ge[l]};
        ovf[l] <= ovf[l] | quo[l][QUO_W-1];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pack) begin
      area <= area_w;
      area_valid <= valid_w;
      centroid_x <= valid_w ? sat_q(quo[0], ovf[0], neg[0]) : '0;
      centroid_y <= valid_w ? sat_q(quo[1], ovf[1], neg[1]) : '0;
    end
  end

endmodule

>>> rtl/core/polygon_area_centroid.sv
// Polygon area and centroid by the shoelace formula: top level.
// A vertex with an edge passes through two registered multiplies and an accumulate.
// Within the vertex limit, the last vertex adds the closing edge and a finish step, then
// the restoring divider if the area is positive, and a pack step that waits for the output.
// The next polygon's vertices are taken while a result word waits at the output register.
// Synchronous reset clears the controller, vertex count, accumulators and output valid.
module polygon_area_centroid #(
  parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pac_pkg::COORD_W-1:0]  vertex_x,
  input  logic signed [pac_pkg::COORD_W-1:0]  vertex_y,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pac_pkg::AREA_W-1:0]   area,
  output logic signed [pac_pkg::COORD_W-1:0]  centroid_x,
  output logic signed [pac_pkg::COORD_W-1:0]  centroid_y,
  output logic                                area_valid
);
  import pac_pkg::*;

  cmd_t    cmd;
  status_t sts;

  pac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pac_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .area        (area),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .area_valid  (area_valid)
  );

endmodule

>>> tb/sv/tb_polygon_area_centroid.sv
// Self-checking testbench for the shoelace polygon area and centroid block.
module tb_polygon_area_centroid;
  timeunit 1ns;
  timeprecision 1ps;

  import pac_pkg::*;

  localparam int MAX_VERTS = MAX_VERTICES_DEF;
  localparam int TOTAL_ITEMS = 1950;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam real TWO_PI = 6.283185307179586;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [AREA_W-1:0]  area;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic                      ok;
  } shape_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t vertex_x = '0;
  coord_t vertex_y = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [AREA_W-1:0] area;
  coord_t centroid_x;
  coord_t centroid_y;
  logic area_valid;

  polygon_area_centroid dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .vertex_x(vertex_x),
    .vertex_y(vertex_y),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .area(area),
    .centroid_x(centroid_x),
    .centroid_y(centroid_y),
    .area_valid(area_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shoelace predictor state
  longint sl_first_x = 0, sl_first_y = 0, sl_prev_x = 0, sl_prev_y = 0;
  longint sl_twice_area = 0, sl_moment_x = 0, sl_moment_y = 0;
  int sl_count = 0;

  shape_result_t pending_results[$];
  coord_t poly_x[$];
  coord_t poly_y[$];

  int mismatches = 0;
  int vertices_taken = 0;
  int polygons_closed = 0;
  int valid_areas = 0;
  int saturated = 0;
  int over_limit = 0;
  int burst_left = 0;

  int stall_left = 0;
  int stall_mode = 0;
  logic [7:0] stall_phase = '0;

  task automatic add_edge(input longint ax, input longint ay, input longint bx,
                          input longint by);
    longint cr;
    cr = ax * by - bx * ay;
    sl_twice_area += cr;
    sl_moment_x += (ax + bx) * cr;
    sl_moment_y += (ay + by) * cr;
  endtask

  function automatic coord_t clamp_q88(input longint v);
    if (v > 32767) begin
      saturated++;
      return SAT_POS;
    end
    if (v < -32768) begin
      saturated++;
      return SAT_NEG;
    end
    return coord_t'(v);
  endfunction

  task automatic predict_vertex(input coord_t vx, input coord_t vy, input logic lst);
    longint x, y, div3;
    shape_result_t res;
    x = vx;
    y = vy;
    if (sl_count == 0) begin
      sl_first_x = x;
      sl_first_y = y;
    end else if (sl_count < MAX_VERTS) begin
      add_edge(sl_prev_x, sl_prev_y, x, y);
    end
    if (sl_count <= MAX_VERTS) sl_count++;
    sl_prev_x = x;
    sl_prev_y = y;
    if (lst) begin
      res.area = '0;
      res.cx = '0;
      res.cy = '0;
      res.ok = 1'b0;
      if (sl_count <= MAX_VERTS) begin
        add_edge(x, y, sl_first_x, sl_first_y);
        res.area = AREA_W'(sl_twice_area / 2);
        if (sl_twice_area > 0) begin
          div3 = 3 * sl_twice_area;
          res.ok = 1'b1;
          res.cx = clamp_q88(sl_moment_x / div3);
          res.cy = clamp_q88(sl_moment_y / div3);
          valid_areas++;
        end
      end else begin
        over_limit++;
      end
      polygons_closed++;
      pending_results.push_back(res);
      sl_first_x = 0;
      sl_first_y = 0;
      sl_prev_x = 0;
      sl_prev_y = 0;
      sl_twice_area = 0;
      sl_moment_x = 0;
      sl_moment_y = 0;
      sl_count = 0;
    end
  endtask

  // check results first, then predict, so a same-edge push never hides a stray word
  always @(posedge clk) begin
    shape_result_t exp_res;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result word: area %0d cx %0d cy %0d valid %0b",
                     area, centroid_x, centroid_y, area_valid);
          mismatches++;
        end else begin
          exp_res = pending_results.pop_front();
          if (area !== exp_res.area || centroid_x !== exp_res.cx ||
              centroid_y !== exp_res.cy || area_valid !== exp_res.ok) begin
            if (mismatches < 10)
              $display("mismatch: exp area %0d cx %0d cy %0d valid %0b, got %0d %0d %0d %0b",
                       exp_res.area, exp_res.cx, exp_res.cy, exp_res.ok,
                       area, centroid_x, centroid_y, area_valid);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_vertex(vertex_x, vertex_y, last_vertex);
        vertices_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(40, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 8'd1;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (stall_phase[3:0] == 4'd0);
      default: out_ready <= stall_phase[0];
    endcase
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_vertex(input coord_t x, input coord_t y, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    vertex_x <= x;
    vertex_y <= y;
    last_vertex <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic add_vertex(input int x, input int y);
    poly_x.push_back(coord_t'(x));
    poly_y.push_back(coord_t'(y));
  endtask

  task automatic send_polygon();
    int n;
    n = poly_x.size();
    for (int i = 0; i < n; i++) send_vertex(poly_x[i], poly_y[i], i == n - 1);
    poly_x.delete();
    poly_y.delete();
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic gen_convex(input int n, input bit ccw, input int radius);
    real w[$];
    real total, ang;
    int lim, cx, cy, px, py;
    lim = 32767 - radius;
    if (lim < 0) lim = 0;
    cx = int'($urandom_range(0, 2 * lim)) - lim;
    cy = int'($urandom_range(0, 2 * lim)) - lim;
    total = 0.0;
    for (int i = 0; i < n; i++) begin
      w.push_back(1.0 + real'($urandom_range(0, 1000)));
      total += w[i];
    end
    ang = TWO_PI * real'($urandom_range(0, 999)) / 1000.0;
    for (int i = 0; i < n; i++) begin
      px = cx + int'(radius * $cos(ang));
      py = cy + int'(radius * $sin(ang));
      if (px > 32767) px = 32767;
      if (px < -32768) px = -32768;
      if (py > 32767) py = 32767;
      if (py < -32768) py = -32768;
      if (ccw) begin
        poly_x.push_back(coord_t'(px));
        poly_y.push_back(coord_t'(py));
      end else begin
        poly_x.push_front(coord_t'(px));
        poly_y.push_front(coord_t'(py));
      end
      ang += TWO_PI * w[i] / total;
    end
  endtask

  task automatic gen_noise(input int n);
    for (int i = 0; i < n; i++) begin
      poly_x.push_back(coord_t'($urandom));
      poly_y.push_back(coord_t'($urandom));
    end
  endtask

  task automatic test_corner_cases();
    // smallest positive twice-area
    add_vertex(0, 0); add_vertex(1, 0); add_vertex(0, 1);
    send_polygon();
    add_vertex(32767, -32768);
    send_polygon();
    add_vertex(-32768, 32767); add_vertex(32767, -32768);
    send_polygon();
    add_vertex(-32768, -32768); add_vertex(32767, -32768);
    add_vertex(32767, 32767); add_vertex(-32768, 32767);
    send_polygon();
    add_vertex(-32768, -32768); add_vertex(-32768, 32767);
    add_vertex(32767, 32767); add_vertex(32767, -32768);
    send_polygon();
    add_vertex(0, 0); add_vertex(256, 256); add_vertex(512, 512);
    send_polygon();
    wait_results_drained();
  endtask

  task automatic test_centroid_saturation();
    // bowtie with nearly cancelling lobes
    add_vertex(-20000, -10000); add_vertex(20000, 10000);
    add_vertex(20000, -10000); add_vertex(-20000, 10001);
    send_polygon();
    add_vertex(20000, 10001); add_vertex(-20000, -10000);
    add_vertex(-20000, 10000); add_vertex(20000, -10000);
    send_polygon();
    add_vertex(10001, -20000); add_vertex(-10000, 20000);
    add_vertex(10000, 20000); add_vertex(-10000, -20000);
    send_polygon();
    wait_results_drained();
  endtask

  task automatic test_vertex_limit();
    gen_convex(MAX_VERTS, 1'b1, 30000);
    send_polygon();
    gen_convex(MAX_VERTS + 1, 1'b1, 30000);
    send_polygon();
    gen_convex(MAX_VERTS + 44, 1'b1, 30000);
    send_polygon();
    wait_results_drained();
  endtask

  task automatic test_random_polygons();
    int pick, n, radius, rsel;
    while (vertices_taken < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        rsel = $urandom_range(0, 9);
        if (rsel < 2) n = $urandom_range(3, 4);
        else if (rsel < 8) n = $urandom_range(5, 10);
        else if (rsel < 9) n = $urandom_range(11, 40);
        else n = $urandom_range(41, 120);
        rsel = $urandom_range(0, 9);
        if (rsel < 2) radius = $urandom_range(1, 64);
        else if (rsel < 6) radius = $urandom_range(64, 4000);
        else radius = $urandom_range(4000, 32000);
        gen_convex(n, pick < 70, radius);
      end else if (pick < 92) begin
        gen_noise($urandom_range(3, 8));
      end else begin
        gen_noise($urandom_range(1, 2));
      end
      send_polygon();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_centroid_saturation();
    test_vertex_limit();
    test_random_polygons();
    $display("covered %0d vertices in %0d polygons, %0d with a valid area",
             vertices_taken, polygons_closed, valid_areas);
    $display("saturated centroid coordinates %0d, over-limit polygons %0d, mismatches %0d",
             saturated, over_limit, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
